// ===== hdl/mef_pkg.sv =====
// Shared types and constants for the motor encoder feedback tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package mef_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int ID_W        = 11;
    localparam int ENC_W       = 16;
    localparam int TURN_W      = 32;
    localparam int ANGLE_W     = 32;
    localparam int COUNT_W     = 8;
    localparam int SLOT_OUT_W  = 4;
    localparam int ENC_BITS    = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_CHASSIS_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIFT_BASE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TURRET_BASE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CALIB_FRAMES = 2'd3;

    localparam logic [ID_W-1:0]    CHASSIS_BASE_RST = 11'd513;
    localparam logic [ID_W-1:0]    LIFT_BASE_RST    = 11'd517;
    localparam logic [ID_W-1:0]    TURRET_BASE_RST  = 11'd517;
    localparam logic [COUNT_W-1:0] CALIB_FRAMES_RST = 8'd50;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam logic signed [ENC_W:0] HALF_TURN_POS = 17'sd4096;
    localparam logic signed [ENC_W:0] HALF_TURN_NEG = -17'sd4096;

    localparam logic ACTION_FRAME = 1'b0;
    localparam logic ACTION_ZERO  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]    chassis_base_id;
        logic [ID_W-1:0]    lift_base_id;
        logic [ID_W-1:0]    turret_base_id;
        logic [COUNT_W-1:0] calib_frames;
    } mef_cfg_t;

    typedef struct packed {
        logic               action;
        logic               bus;
        logic [ID_W-1:0]    can_id;
        logic [ENC_W-1:0]   encoder_raw;
        logic signed [15:0] speed_raw;
        logic signed [15:0] current_in;
        logic [7:0]         temperature;
    } mef_item_t;

    typedef struct packed {
        logic                      matched;
        logic [SLOT_OUT_W-1:0]     slot;
        logic                      calibrating;
        logic signed [ANGLE_W-1:0] relative_angle;
        logic signed [ANGLE_W-1:0] absolute_angle;
        logic signed [15:0]        speed_out;
        logic signed [15:0]        current_out;
        logic [7:0]                temperature_out;
    } mef_result_t;

endpackage

`default_nettype wire

// ===== hdl/mef_slot_dec.sv =====
// Bus and identifier to motor slot decoder.
// Depends on mef_pkg.
`default_nettype none

module mef_slot_dec
    import mef_pkg::*;
#(
    parameter int CHASSIS_MOTORS = 4,
    parameter int LIFT_MOTORS    = 3,
    parameter int TURRET_MOTORS  = 2,
    localparam int SLOT_COUNT    = CHASSIS_MOTORS + LIFT_MOTORS + TURRET_MOTORS,
    localparam int SLOT_W        = $clog2(SLOT_COUNT)
) (
    input  mef_cfg_t          cfg,
    input  logic              bus,
    input  logic [ID_W-1:0]   can_id,
    output logic              matched,
    output logic [SLOT_W-1:0] slot_idx
);

    logic [ID_W-1:0] d_chassis;
    logic [ID_W-1:0] d_lift;
    logic [ID_W-1:0] d_turret;
    logic            hit_chassis;
    logic            hit_lift;
    logic            hit_turret;

    assign d_chassis = can_id - cfg.chassis_base_id;
    assign d_lift    = can_id - cfg.lift_base_id;
    assign d_turret  = can_id - cfg.turret_base_id;

    assign hit_chassis = (can_id >= cfg.chassis_base_id) && (d_chassis < ID_W'(CHASSIS_MOTORS));
    assign hit_lift    = (can_id >= cfg.lift_base_id) && (d_lift < ID_W'(LIFT_MOTORS));
    assign hit_turret  = (can_id >= cfg.turret_base_id) && (d_turret < ID_W'(TURRET_MOTORS));

    always_comb begin
        matched  = 1'b0;
        slot_idx = '0;
        if (!bus) begin
            if (hit_chassis) begin
                matched  = 1'b1;
                slot_idx = SLOT_W'(d_chassis);
            end else if (hit_lift) begin
                matched  = 1'b1;
                slot_idx = SLOT_W'(CHASSIS_MOTORS) + SLOT_W'(d_lift);
            end
        end else if (hit_turret) begin
            matched  = 1'b1;
            slot_idx = SLOT_W'(CHASSIS_MOTORS + LIFT_MOTORS) + SLOT_W'(d_turret);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mef_slot_track.sv =====
// Per-slot encoder state with read-modify-write and combinational angle compute.
// Depends on mef_pkg.
`default_nettype none

module mef_slot_track
    import mef_pkg::*;
#(
    parameter int CHASSIS_MOTORS = 4,
    parameter int LIFT_MOTORS    = 3,
    parameter int TURRET_MOTORS  = 2,
    localparam int SLOT_COUNT    = CHASSIS_MOTORS + LIFT_MOTORS + TURRET_MOTORS,
    localparam int SLOT_W        = $clog2(SLOT_COUNT)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  mef_cfg_t          cfg,
    input  mef_item_t         item,
    input  logic              matched,
    input  logic [SLOT_W-1:0] slot_idx,
    output mef_result_t       result
);

    logic [COUNT_W-1:0] frame_count_reg  [SLOT_COUNT];
    logic [ENC_W-1:0]   encoder_now_reg  [SLOT_COUNT];
    logic [ENC_W-1:0]   encoder_prev_reg [SLOT_COUNT];
    logic [TURN_W-1:0]  turn_count_reg   [SLOT_COUNT];
    logic [ENC_W-1:0]   zero_offset_reg  [SLOT_COUNT];

    logic [COUNT_W-1:0] fc_cur;
    logic [ENC_W-1:0]   en_cur;
    logic [TURN_W-1:0]  tc_cur;
    logic [ENC_W-1:0]   zo_cur;

    logic [COUNT_W-1:0] fc_next;
    logic [ENC_W-1:0]   en_next;
    logic [ENC_W-1:0]   ep_next;
    logic [TURN_W-1:0]  tc_next;
    logic [ENC_W-1:0]   zo_next;

    logic signed [ENC_W:0]  diff;
    logic                   calib;
    logic [ANGLE_W-1:0]     base;

    assign fc_cur = frame_count_reg[slot_idx];
    assign en_cur = encoder_now_reg[slot_idx];
    assign tc_cur = turn_count_reg[slot_idx];
    assign zo_cur = zero_offset_reg[slot_idx];

    assign diff = $signed({1'b0, item.encoder_raw}) - $signed({1'b0, en_cur});

    always_comb begin
        fc_next = fc_cur;
        en_next = en_cur;
        ep_next = encoder_prev_reg[slot_idx];
        tc_next = tc_cur;
        zo_next = zo_cur;
        calib   = 1'b0;
        if (item.action == ACTION_ZERO) begin
            zo_next = en_cur;
            ep_next = en_cur;
            tc_next = '0;
        end else if (fc_cur <= cfg.calib_frames) begin
            if (fc_cur != COUNT_MAX) begin
                fc_next = fc_cur + 1'b1;
            end
            en_next = item.encoder_raw;
            zo_next = item.encoder_raw;
            calib   = 1'b1;
        end else begin
            ep_next = en_cur;
            en_next = item.encoder_raw;
            if (diff > HALF_TURN_POS) begin
                tc_next = tc_cur - 1'b1;
            end else if (diff < HALF_TURN_NEG) begin
                tc_next = tc_cur + 1'b1;
            end
        end
    end

    assign base = {tc_next[ANGLE_W-ENC_BITS-1:0], {ENC_BITS{1'b0}}}
                + {{(ANGLE_W-ENC_W){1'b0}}, en_next};

    always_comb begin
        result = '0;
        if (matched) begin
            result.matched        = 1'b1;
            result.slot           = SLOT_OUT_W'(slot_idx);
            result.calibrating    = calib;
            result.relative_angle = base - {{(ANGLE_W-ENC_W){1'b0}}, zo_next};
            result.absolute_angle = base;
            if (item.action == ACTION_FRAME && !calib) begin
                result.speed_out       = item.speed_raw;
                result.current_out     = item.current_in;
                result.temperature_out = item.temperature;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                frame_count_reg[i]  <= '0;
                encoder_now_reg[i]  <= '0;
                encoder_prev_reg[i] <= '0;
                turn_count_reg[i]   <= '0;
                zero_offset_reg[i]  <= '0;
            end
        end else if (advance && matched) begin
            frame_count_reg[slot_idx]  <= fc_next;
            encoder_now_reg[slot_idx]  <= en_next;
            encoder_prev_reg[slot_idx] <= ep_next;
            turn_count_reg[slot_idx]   <= tc_next;
            zero_offset_reg[slot_idx]  <= zo_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/motor_encoder_feedback_tracker_top.sv =====
// Top level of the motor encoder feedback tracker: stream ports, configuration
// registers, input and result registers. Depends on mef_pkg, mef_slot_dec,
// mef_slot_track.
//
// Usage:
//   s_ channel carries one feedback frame or zero request per transfer; m_
//   channel returns exactly one result per accepted item, in order. A frame
//   whose bus and identifier select no motor slot returns an all-zero result.
//   cfg_ channel writes the four configuration registers by index; it is
//   always ready and must only be used while the block is idle.
//   Path: an input transfer fills the input register; its result is then
//   loaded into the result register, from which it is offered on m_.
//   Throughput: one item per cycle while m_ is not stalled; each slot's
//   state is read, updated and written back between the two registers.
//   Reset: aresetn low clears all slot state, both valid flags and loads
//   the configuration defaults.
//   Stall: when m_tready is low the result register holds, the input
//   register still fills, and s_tready drops once both are occupied.
`default_nettype none

module motor_encoder_feedback_tracker_top
    import mef_pkg::*;
#(
    parameter int CHASSIS_MOTORS = 4,
    parameter int LIFT_MOTORS    = 3,
    parameter int TURRET_MOTORS  = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // can_id[10:0], encoder_raw[26:11], speed_raw[42:27], current_in[58:43],
    // temperature[66:59], zero pad[71:67]
    input  logic [71:0]            s_tdata,
    // action[0], bus[1]
    input  logic [1:0]             s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // slot[3:0], relative_angle[35:4], absolute_angle[67:36], speed_out[83:68],
    // current_out[99:84], temperature_out[107:100], zero pad[111:108]
    output logic [111:0]           m_tdata,
    // matched[0], calibrating[1]
    output logic [1:0]             m_tuser
);

    localparam int SLOT_COUNT = CHASSIS_MOTORS + LIFT_MOTORS + TURRET_MOTORS;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    mef_cfg_t    cfg_reg;
    mef_item_t   item_reg;
    logic        item_valid_reg;
    mef_result_t result_reg;
    logic        result_valid_reg;

    mef_result_t       result_next;
    logic              matched;
    logic [SLOT_W-1:0] slot_idx;
    logic              advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.chassis_base_id <= CHASSIS_BASE_RST;
            cfg_reg.lift_base_id    <= LIFT_BASE_RST;
            cfg_reg.turret_base_id  <= TURRET_BASE_RST;
            cfg_reg.calib_frames    <= CALIB_FRAMES_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CHASSIS_BASE: cfg_reg.chassis_base_id <= cfg_data;
                REG_LIFT_BASE:    cfg_reg.lift_base_id    <= cfg_data;
                REG_TURRET_BASE:  cfg_reg.turret_base_id  <= cfg_data;
                REG_CALIB_FRAMES: cfg_reg.calib_frames    <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance  = item_valid_reg && (!result_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.action      <= s_tuser[0];
            item_reg.bus         <= s_tuser[1];
            item_reg.can_id      <= s_tdata[10:0];
            item_reg.encoder_raw <= s_tdata[26:11];
            item_reg.speed_raw   <= s_tdata[42:27];
            item_reg.current_in  <= s_tdata[58:43];
            item_reg.temperature <= s_tdata[66:59];
        end
    end

    mef_slot_dec #(
        .CHASSIS_MOTORS (CHASSIS_MOTORS),
        .LIFT_MOTORS    (LIFT_MOTORS),
        .TURRET_MOTORS  (TURRET_MOTORS)
    ) u_slot_dec (
        .cfg      (cfg_reg),
        .bus      (item_reg.bus),
        .can_id   (item_reg.can_id),
        .matched  (matched),
        .slot_idx (slot_idx)
    );

    mef_slot_track #(
        .CHASSIS_MOTORS (CHASSIS_MOTORS),
        .LIFT_MOTORS    (LIFT_MOTORS),
        .TURRET_MOTORS  (TURRET_MOTORS)
    ) u_slot_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .cfg      (cfg_reg),
        .item     (item_reg),
        .matched  (matched),
        .slot_idx (slot_idx),
        .result   (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_valid_reg <= 1'b0;
        end else if (advance) begin
            result_valid_reg <= 1'b1;
        end else if (m_tready) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = result_valid_reg;
    assign m_tuser  = {result_reg.calibrating, result_reg.matched};
    assign m_tdata  = {4'b0,
                       result_reg.temperature_out,
                       result_reg.current_out,
                       result_reg.speed_out,
                       result_reg.absolute_angle,
                       result_reg.relative_angle,
                       result_reg.slot};

endmodule

`default_nettype wire

// ===== tb/tb_motor_encoder_feedback_tracker_top.sv =====
// Testbench for motor_encoder_feedback_tracker_top: a directed table, then random
// phases under several register settings, every result checked against table values
// or a local slot tracker. Depends on mef_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_motor_encoder_feedback_tracker_top;
    import mef_pkg::*;

    localparam int CHASSIS_N   = 4;
    localparam int LIFT_N      = 3;
    localparam int TURRET_N    = 2;
    localparam int SLOT_N      = CHASSIS_N + LIFT_N + TURRET_N;
    localparam int HALF_REV    = 4096;
    localparam int LATENCY     = 2;
    localparam int PHASE_N     = 5;
    localparam int FOCUS_PHASE = 2;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        mef_item_t                  item;
        bit                         known;
        mef_result_t                res;
        logic [CFG_INDEX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]      reg_val;
    } row_t;

    typedef struct {
        logic [ID_W-1:0]    chassis;
        logic [ID_W-1:0]    lift;
        logic [ID_W-1:0]    turret;
        logic [COUNT_W-1:0] calib;
        int                 items;
        int                 idle;
    } phase_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [71:0]            s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [111:0]           m_tdata;
    logic [1:0]             m_tuser;

    motor_encoder_feedback_tracker_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // local copy of the block's configuration and per-slot state
    logic [ID_W-1:0]    cfg_chassis;
    logic [ID_W-1:0]    cfg_lift;
    logic [ID_W-1:0]    cfg_turret;
    logic [COUNT_W-1:0] cfg_calib;
    logic [COUNT_W-1:0] frames_seen [SLOT_N];
    logic [ENC_W-1:0]   enc_now     [SLOT_N];
    logic [ENC_W-1:0]   enc_prev    [SLOT_N];
    logic [TURN_W-1:0]  turns       [SLOT_N];
    logic [ENC_W-1:0]   zero_pos    [SLOT_N];

    mef_result_t pending_results [$];
    row_t        plan [$];
    phase_t      phases [PHASE_N];

    int idle_pct      = 30;
    int errors        = 0;
    int items_sent    = 0;
    int zero_requests = 0;
    int unmatched     = 0;
    int turn_steps    = 0;
    int calib_frames_seen = 0;
    int reg_writes    = 0;
    int results_checked = 0;

    function automatic int motor_slot(input logic bus, input logic [ID_W-1:0] id);
        int idv;
        int cb;
        int lb;
        int tb;
        idv = int'(id);
        cb  = int'(cfg_chassis);
        lb  = int'(cfg_lift);
        tb  = int'(cfg_turret);
        if (bus == 1'b0) begin
            if (idv >= cb && idv - cb < CHASSIS_N) return idv - cb;
            if (idv >= lb && idv - lb < LIFT_N) return CHASSIS_N + idv - lb;
            return -1;
        end
        if (idv >= tb && idv - tb < TURRET_N) return CHASSIS_N + LIFT_N + idv - tb;
        return -1;
    endfunction

    function automatic mef_result_t track_frame(input mef_item_t it);
        mef_result_t        r;
        int                 s;
        int                 a;
        int                 b;
        int                 diff;
        logic [ANGLE_W-1:0] base;
        r = '0;
        items_sent++;
        s = motor_slot(it.bus, it.can_id);
        if (s < 0) begin
            unmatched++;
            return r;
        end
        if (it.action == ACTION_ZERO) begin
            zero_requests++;
            zero_pos[s] = enc_now[s];
            enc_prev[s] = enc_now[s];
            turns[s]    = '0;
        end else if (frames_seen[s] <= cfg_calib) begin
            calib_frames_seen++;
            if (frames_seen[s] != COUNT_MAX) frames_seen[s]++;
            enc_now[s]    = it.encoder_raw;
            zero_pos[s]   = it.encoder_raw;
            r.calibrating = 1'b1;
        end else begin
            enc_prev[s] = enc_now[s];
            enc_now[s]  = it.encoder_raw;
            a = int'(enc_now[s]);
            b = int'(enc_prev[s]);
            diff = a - b;
            if (diff > HALF_REV) begin
                turns[s] = turns[s] - 32'd1;
                turn_steps++;
            end else if (diff < -HALF_REV) begin
                turns[s] = turns[s] + 32'd1;
                turn_steps++;
            end
            r.speed_out       = it.speed_raw;
            r.current_out     = it.current_in;
            r.temperature_out = it.temperature;
        end
        base = turns[s] * 32'd8192 + {16'b0, enc_now[s]};
        r.matched        = 1'b1;
        r.slot           = SLOT_OUT_W'(s);
        r.relative_angle = base - {16'b0, zero_pos[s]};
        r.absolute_angle = base;
        return r;
    endfunction

    task automatic reset_tracker();
        cfg_chassis = CHASSIS_BASE_RST;
        cfg_lift    = LIFT_BASE_RST;
        cfg_turret  = TURRET_BASE_RST;
        cfg_calib   = CALIB_FRAMES_RST;
        for (int i = 0; i < SLOT_N; i++) begin
            frames_seen[i] = '0;
            enc_now[i]     = '0;
            enc_prev[i]    = '0;
            turns[i]       = '0;
            zero_pos[i]    = '0;
        end
    endtask

    function automatic mef_item_t make_item(input logic action, input logic bus,
                                            input logic [ID_W-1:0] id,
                                            input logic [ENC_W-1:0] enc,
                                            input logic [15:0] spd, input logic [15:0] cur,
                                            input logic [7:0] tmp);
        mef_item_t it;
        it.action      = action;
        it.bus         = bus;
        it.can_id      = id;
        it.encoder_raw = enc;
        it.speed_raw   = spd;
        it.current_in  = cur;
        it.temperature = tmp;
        return it;
    endfunction

    task automatic add_item(input logic action, input logic bus, input logic [ID_W-1:0] id,
                            input logic [ENC_W-1:0] enc, input logic [15:0] spd,
                            input logic [15:0] cur, input logic [7:0] tmp);
        row_t row;
        row       = '{kind: ROW_ITEM, default: '0};
        row.kind  = ROW_ITEM;
        row.item  = make_item(action, bus, id, enc, spd, cur, tmp);
        row.known = 1'b0;
        plan.push_back(row);
    endtask

    // a row whose pass-through fields are expected to be zero
    task automatic add_known(input logic action, input logic bus, input logic [ID_W-1:0] id,
                             input logic [ENC_W-1:0] enc, input logic m,
                             input logic [SLOT_OUT_W-1:0] slot, input logic calib,
                             input logic [ANGLE_W-1:0] rel, input logic [ANGLE_W-1:0] abs_a);
        row_t row;
        row                    = '{kind: ROW_ITEM, default: '0};
        row.kind               = ROW_ITEM;
        row.item               = make_item(action, bus, id, enc, 16'h7fff, 16'h8000, 8'hff);
        row.known              = 1'b1;
        row.res                = '0;
        row.res.matched        = m;
        row.res.slot           = slot;
        row.res.calibrating    = calib;
        row.res.relative_angle = rel;
        row.res.absolute_angle = abs_a;
        plan.push_back(row);
    endtask

    task automatic add_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        row_t row;
        row         = '{kind: ROW_REG, default: '0};
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CHASSIS_BASE: cfg_chassis = val;
            REG_LIFT_BASE:    cfg_lift    = val;
            REG_TURRET_BASE:  cfg_turret  = val;
            REG_CALIB_FRAMES: cfg_calib   = val[COUNT_W-1:0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(input mef_item_t it, output mef_result_t r);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, it.temperature, it.current_in, it.speed_raw,
                     it.encoder_raw, it.can_id};
        s_tuser  <= {it.bus, it.action};
        do @(posedge aclk); while (!s_tready);
        r = track_frame(it);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic random_item(input bit focus, output mef_item_t it);
        int               s;
        int               roll;
        logic             bus;
        logic [ID_W-1:0]  id;
        logic [ENC_W-1:0] enc;
        logic [ENC_W-1:0] step;
        it = make_item(1'($urandom), 1'($urandom), ID_W'($urandom), ENC_W'($urandom),
                       16'($urandom), 16'($urandom), 8'($urandom));
        if ($urandom_range(0, 99) < 12) return;
        if (focus && $urandom_range(0, 99) < 90) s = 0;
        else s = $urandom_range(0, SLOT_N - 1);
        if (s < CHASSIS_N) begin
            bus = 1'b0;
            id  = cfg_chassis + ID_W'(s);
        end else if (s < CHASSIS_N + LIFT_N) begin
            bus = 1'b0;
            id  = cfg_lift + ID_W'(s - CHASSIS_N);
        end else begin
            bus = 1'b1;
            id  = cfg_turret + ID_W'(s - CHASSIS_N - LIFT_N);
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            step = ENC_W'($urandom_range(0, 2000)) - 16'd1000;
            enc  = (enc_now[s] + step) & 16'h1fff;
        end else if (roll < 75) begin
            step = ENC_W'(HALF_REV - 1 + $urandom_range(0, 2));
            enc  = $urandom_range(0, 1) ? enc_now[s] + step : enc_now[s] - step;
        end else begin
            enc = ENC_W'($urandom);
        end
        it.action      = ($urandom_range(0, 99) < 6) ? ACTION_ZERO : ACTION_FRAME;
        it.bus         = bus;
        it.can_id      = id;
        it.encoder_raw = enc;
    endtask

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
        end
    endtask

    task automatic check_result();
        mef_result_t got;
        mef_result_t want;
        got.matched         = m_tuser[0];
        got.calibrating     = m_tuser[1];
        got.slot            = m_tdata[3:0];
        got.relative_angle  = m_tdata[35:4];
        got.absolute_angle  = m_tdata[67:36];
        got.speed_out       = m_tdata[83:68];
        got.current_out     = m_tdata[99:84];
        got.temperature_out = m_tdata[107:100];
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, actual 0x%0h", $time, got);
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        check_field("matched",         32'(want.matched),         32'(got.matched));
        check_field("slot",            32'(want.slot),            32'(got.slot));
        check_field("calibrating",     32'(want.calibrating),     32'(got.calibrating));
        check_field("relative_angle",  want.relative_angle,       got.relative_angle);
        check_field("absolute_angle",  want.absolute_angle,       got.absolute_angle);
        check_field("speed_out",       32'(want.speed_out),       32'(got.speed_out));
        check_field("current_out",     32'(want.current_out),     32'(got.current_out));
        check_field("temperature_out", 32'(want.temperature_out), 32'(got.temperature_out));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result();
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        mef_item_t   it;
        mef_result_t r;

        reset_tracker();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // defaults: no match, offset capture per range, zero before any frame
        add_known(ACTION_FRAME, 1'b0, 11'd0,    16'hffff, 1'b0, 4'd0, 1'b0, 32'd0, 32'd0);
        add_known(ACTION_FRAME, 1'b1, 11'd2047, 16'h0000, 1'b0, 4'd0, 1'b0, 32'd0, 32'd0);
        add_known(ACTION_FRAME, 1'b0, 11'd513,  16'h1234, 1'b1, 4'd0, 1'b1, 32'd0, 32'h1234);
        add_known(ACTION_ZERO,  1'b0, 11'd513,  16'hffff, 1'b1, 4'd0, 1'b0, 32'd0, 32'h1234);
        add_known(ACTION_ZERO,  1'b0, 11'd514,  16'h5555, 1'b1, 4'd1, 1'b0, 32'd0, 32'd0);
        add_known(ACTION_FRAME, 1'b0, 11'd516,  16'hffff, 1'b1, 4'd3, 1'b1, 32'd0, 32'hffff);
        add_known(ACTION_FRAME, 1'b0, 11'd517,  16'h8000, 1'b1, 4'd4, 1'b1, 32'd0, 32'h8000);
        add_known(ACTION_FRAME, 1'b0, 11'd519,  16'h0001, 1'b1, 4'd6, 1'b1, 32'd0, 32'h0001);
        add_known(ACTION_FRAME, 1'b0, 11'd520,  16'h0001, 1'b0, 4'd0, 1'b0, 32'd0, 32'd0);
        add_known(ACTION_FRAME, 1'b1, 11'd517,  16'h1fff, 1'b1, 4'd7, 1'b1, 32'd0, 32'h1fff);
        add_known(ACTION_FRAME, 1'b1, 11'd518,  16'h0002, 1'b1, 4'd8, 1'b1, 32'd0, 32'h0002);
        add_known(ACTION_FRAME, 1'b1, 11'd519,  16'h0002, 1'b0, 4'd0, 1'b0, 32'd0, 32'd0);
        // no capture, overlapping chassis and lift ranges, extreme bases
        add_reg(REG_CALIB_FRAMES, 11'd0);
        add_reg(REG_CHASSIS_BASE, 11'd0);
        add_reg(REG_LIFT_BASE,    11'd2);
        add_reg(REG_TURRET_BASE,  11'd2047);
        add_item(ACTION_FRAME, 1'b0, 11'd0,    16'h0000, 16'h7fff, 16'h8000, 8'hff);
        add_item(ACTION_FRAME, 1'b0, 11'd0,    16'h1000, 16'h8000, 16'h7fff, 8'h00);
        add_item(ACTION_FRAME, 1'b0, 11'd0,    16'h0000, 16'h0001, 16'hffff, 8'h80);
        add_item(ACTION_FRAME, 1'b0, 11'd0,    16'h1001, 16'hffff, 16'h0001, 8'h7f);
        add_item(ACTION_FRAME, 1'b0, 11'd0,    16'hffff, 16'h1234, 16'hedcb, 8'h5a);
        add_item(ACTION_ZERO,  1'b0, 11'd0,    16'h0000, 16'h1111, 16'h2222, 8'h33);
        add_item(ACTION_FRAME, 1'b0, 11'd4,    16'h0000, 16'h4444, 16'h5555, 8'h66);
        add_item(ACTION_FRAME, 1'b1, 11'd2047, 16'h7fff, 16'h7777, 16'h8888, 8'h99);
        add_item(ACTION_FRAME, 1'b0, 11'd2047, 16'h0100, 16'h7fff, 16'h7fff, 8'hff);
        add_item(ACTION_FRAME, 1'b0, 11'd3,    16'h0abc, 16'h8000, 16'h8000, 8'h01);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                if (i == 0 || plan[i-1].kind != ROW_REG) wait_drained();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i].item, r);
                pending_results.push_back(plan[i].known ? plan[i].res : r);
            end
        end

        phases[0] = '{11'd513,  11'd517,  11'd517,  8'd3,   220, 30};
        phases[1] = '{11'd0,    11'd2047, 11'd2047, 8'd0,   220, 0};
        phases[2] = '{11'd100,  11'd102,  11'd0,    8'd255, 380, 30};
        phases[3] = '{11'd2044, 11'd1000, 11'd2046, 8'd1,   220, 30};
        phases[4] = '{ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
                       ID_W'($urandom_range(0, 2047)), COUNT_W'($urandom_range(0, 8)), 220, 30};

        for (int p = 0; p < PHASE_N; p++) begin
            wait_drained();
            write_reg(REG_CHASSIS_BASE, phases[p].chassis);
            write_reg(REG_LIFT_BASE,    phases[p].lift);
            write_reg(REG_TURRET_BASE,  phases[p].turret);
            write_reg(REG_CALIB_FRAMES, CFG_DATA_W'(phases[p].calib));
            idle_pct = phases[p].idle;
            for (int n = 0; n < phases[p].items; n++) begin
                // hold the sender until the block has drained
                if (n == phases[p].items / 2) wait_drained();
                random_item(p == FOCUS_PHASE, it);
                send_item(it, r);
                pending_results.push_back(r);
            end
        end

        wait_drained();
        repeat (4 * LATENCY) @(posedge aclk);

        $display("Sent %0d items (%0d zero requests, %0d unmatched, %0d capture frames)",
                 items_sent, zero_requests, unmatched, calib_frames_seen);
        $display("Checked %0d results over %0d register writes; %0d turn steps tracked",
                 results_checked, reg_writes, turn_steps);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
